// ===== hdl/dfs_pkg.sv =====
`timescale 1ns / 1ps
package dfs_pkg;

  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] RegMode   = 2'd0;
  localparam logic [1:0] RegEsc1st = 2'd1;
  localparam logic [1:0] RegEsc2nd = 2'd2;
  localparam logic [1:0] RegEsc3rd = 2'd3;

  localparam logic [7:0] Esc1stReset = 8'd100;
  localparam logic [7:0] Esc2ndReset = 8'd108;
  localparam logic [7:0] Esc3rdReset = 8'd101;

  localparam logic ModeStuff   = 1'b0;
  localparam logic ModeDestuff = 1'b1;

  // result positions within one item's run
  localparam logic [3:0] PosHdr0  = 4'd0;
  localparam logic [3:0] PosHdr5  = 4'd5;
  localparam logic [3:0] PosChar  = 4'd6;
  localparam logic [3:0] PosCopy0 = 4'd7;
  localparam logic [3:0] PosCopy1 = 4'd8;
  localparam logic [3:0] PosCopy2 = 4'd9;
  localparam logic [3:0] PosTrl0  = 4'd10;
  localparam logic [3:0] PosTrl5  = 4'd15;

  typedef struct packed {
    logic       mode;
    logic [7:0] esc1st;
    logic [7:0] esc2nd;
    logic [7:0] esc3rd;
  } cfg_t;

  // one classified item as handed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       hdr;   // open frame first
    logic       cpy;   // insert pattern copy after char
    logic       trl;   // close frame after char
    logic       err;   // destuff copy mismatch
    logic       fin;   // destuff: char ends the message
  } desc_t;

  function automatic logic [7:0] header_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h44; // D
      3'd1:    c = 8'h4C; // L
      3'd2:    c = 8'h45; // E
      3'd3:    c = 8'h53; // S
      3'd4:    c = 8'h54; // T
      3'd5:    c = 8'h58; // X
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] trailer_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h44; // D
      3'd1:    c = 8'h4C; // L
      3'd2:    c = 8'h45; // E
      3'd3:    c = 8'h45; // E
      3'd4:    c = 8'h54; // T
      3'd5:    c = 8'h58; // X
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/dle_frame_stuffer.sv =====
`timescale 1ns / 1ps
// DLE character framer/deframer. Stuff mode (mode 0) opens each frame with
// "DLESTX", passes payload, inserts a copy of the three-character escape
// pattern after each complete pattern, and closes with "DLEETX" after the
// character marked end_of_message. Destuff mode (1) passes characters and
// drops the three that follow each pattern, flagging a mismatching one with
// stuffing_error. The front end classifies one character per cycle unless
// the queue is full and queues a descriptor per passed character; the back
// end expands each into header, character, copy and trailer as flagged.
// Plain characters stream at one per cycle while out_ready_i is high; the
// QueueDepth-entry queue absorbs bursts of longer runs. Config registers
// (APB, word addresses 0x0..0xC): mode, escape_first, escape_second,
// escape_third; write only while idle.
module dle_frame_stuffer import dfs_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_char_i,
  input  logic                 end_of_message_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_char_o,
  output logic                 last_of_run_o,
  output logic                 frame_done_o,
  output logic                 stuffing_error_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;
  logic       in_xfer;
  logic       push, pop, q_full, q_valid;
  desc_t      push_desc, head_desc;

  // ---- register file ----
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= ModeStuff;
      cfg_q.esc1st <= Esc1stReset;
      cfg_q.esc2nd <= Esc2ndReset;
      cfg_q.esc3rd <= Esc3rdReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegMode:   cfg_q.mode   <= pwdata[0];
        RegEsc1st: cfg_q.esc1st <= pwdata[7:0];
        RegEsc2nd: cfg_q.esc2nd <= pwdata[7:0];
        RegEsc3rd: cfg_q.esc3rd <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegMode:   prdata = {{(DataWidth-1){1'b0}}, cfg_q.mode};
      RegEsc1st: prdata = {{(DataWidth-8){1'b0}}, cfg_q.esc1st};
      RegEsc2nd: prdata = {{(DataWidth-8){1'b0}}, cfg_q.esc2nd};
      RegEsc3rd: prdata = {{(DataWidth-8){1'b0}}, cfg_q.esc3rd};
      default:   prdata = '0;
    endcase
  end

  // ---- front: accept and classify ----
  // ready only depends on queue space, so a dropped character is taken too
  assign in_ready_o = !q_full;
  assign in_xfer    = in_valid_i && in_ready_o;

  dfs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .acc_i            (in_xfer),
    .data_char_i      (data_char_i),
    .end_of_message_i (end_of_message_i),
    .push_o           (push),
    .desc_o           (push_desc)
  );

  dfs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_desc),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .rdata_o (head_desc)
  );

  // ---- back: expand descriptor into result run ----
  dfs_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .head_valid_i     (q_valid),
    .head_i           (head_desc),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_char_o       (out_char_o),
    .last_of_run_o    (last_of_run_o),
    .frame_done_o     (frame_done_o),
    .stuffing_error_o (stuffing_error_o)
  );

endmodule

// ===== hdl/dfs_front.sv =====
`timescale 1ns / 1ps
module dfs_front import dfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       acc_i,     // input transfer this cycle
  input  logic [7:0] data_char_i,
  input  logic       end_of_message_i,
  output logic       push_o,
  output desc_t      desc_o
);

  logic        inside_q, inside_d;
  logic [15:0] hist_q, hist_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [1:0]  skip_q, skip_d;
  logic        match;
  logic [7:0]  expect_ch;
  logic [1:0]  cnt_inc;

  assign match = (cnt_q == 2'd2) && (hist_q[15:8] == cfg_i.esc1st) &&
                 (hist_q[7:0] == cfg_i.esc2nd) && (data_char_i == cfg_i.esc3rd);
  assign cnt_inc = (cnt_q == 2'd2) ? 2'd2 : cnt_q + 2'd1;

  always_comb begin
    case (skip_q)
      2'd3:    expect_ch = cfg_i.esc1st;
      2'd2:    expect_ch = cfg_i.esc2nd;
      default: expect_ch = cfg_i.esc3rd;
    endcase
  end

  always_comb begin
    inside_d = inside_q;
    hist_d   = hist_q;
    cnt_d    = cnt_q;
    skip_d   = skip_q;
    push_o   = 1'b0;
    desc_o   = '0;
    desc_o.ch = data_char_i;
    if (acc_i) begin
      if (cfg_i.mode == ModeStuff) begin
        push_o     = 1'b1;
        desc_o.hdr = !inside_q;
        desc_o.cpy = match;
        desc_o.trl = end_of_message_i;
        inside_d   = 1'b1;
        if (match) begin
          hist_d = '0;
          cnt_d  = 2'd0;
        end else begin
          hist_d = {hist_q[7:0], data_char_i};
          cnt_d  = cnt_inc;
        end
      end else begin
        if (skip_q != 2'd0) begin
          if (data_char_i == expect_ch) begin
            skip_d = skip_q - 2'd1;
          end else begin
            // mismatch: char passes flagged and restarts history
            skip_d     = 2'd0;
            push_o     = 1'b1;
            desc_o.err = 1'b1;
            hist_d     = {8'h00, data_char_i};
            cnt_d      = 2'd1;
          end
        end else begin
          push_o = 1'b1;
          if (match) begin
            skip_d = 2'd3;
            hist_d = '0;
            cnt_d  = 2'd0;
          end else begin
            hist_d = {hist_q[7:0], data_char_i};
            cnt_d  = cnt_inc;
          end
        end
        desc_o.fin = end_of_message_i;
      end
      if (end_of_message_i) begin
        inside_d = 1'b0;
        skip_d   = 2'd0;
        hist_d   = '0;
        cnt_d    = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q <= 1'b0;
      hist_q   <= '0;
      cnt_q    <= '0;
      skip_q   <= '0;
    end else begin
      inside_q <= inside_d;
      hist_q   <= hist_d;
      cnt_q    <= cnt_d;
      skip_q   <= skip_d;
    end
  end

endmodule

// ===== hdl/dfs_queue.sv =====
`timescale 1ns / 1ps
module dfs_queue import dfs_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t wdata_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output desc_t rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  desc_t           slot_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrMax) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrMax) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== hdl/dfs_back.sv =====
`timescale 1ns / 1ps
module dfs_back import dfs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       head_valid_i,
  input  desc_t      head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_of_run_o,
  output logic       frame_done_o,
  output logic       stuffing_error_o
);

  logic       busy_q;
  logic [3:0] pos_q;
  logic [3:0] cur_pos, nxt_pos, trl_idx;
  logic       last, adv, emit;
  logic       vld_q;
  logic [7:0] ch_q;
  logic       lst_q, done_q, err_q;
  logic [7:0] ch_d;
  logic       done_d;

  assign cur_pos = busy_q ? pos_q : (head_i.hdr ? PosHdr0 : PosChar);
  assign trl_idx = cur_pos - PosTrl0;
  assign adv     = !vld_q || out_ready_i;
  assign emit    = adv && head_valid_i;
  assign pop_o   = emit && last;

  always_comb begin
    nxt_pos = cur_pos + 4'd1;
    last    = 1'b0;
    case (cur_pos)
      PosChar: begin
        if (head_i.cpy) begin
          nxt_pos = PosCopy0;
        end else if (head_i.trl) begin
          nxt_pos = PosTrl0;
        end else begin
          last = 1'b1;
        end
      end
      PosCopy2: begin
        if (head_i.trl) begin
          nxt_pos = PosTrl0;
        end else begin
          last = 1'b1;
        end
      end
      PosTrl5: last = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    done_d = 1'b0;
    case (cur_pos) inside
      [PosHdr0:PosHdr5]: ch_d = header_char(cur_pos[2:0]);
      PosChar: begin
        ch_d   = head_i.ch;
        done_d = head_i.fin && last;
      end
      PosCopy0: ch_d = cfg_i.esc1st;
      PosCopy1: ch_d = cfg_i.esc2nd;
      PosCopy2: ch_d = cfg_i.esc3rd;
      default: begin
        ch_d   = trailer_char(trl_idx[2:0]);
        done_d = (cur_pos == PosTrl5);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
      vld_q  <= 1'b0;
    end else begin
      if (emit) begin
        busy_q <= !last;
        pos_q  <= nxt_pos;
        vld_q  <= 1'b1;
      end else if (adv) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ch_q   <= ch_d;
      lst_q  <= last;
      done_q <= done_d;
      err_q  <= (cur_pos == PosChar) && head_i.err;
    end
  end

  assign out_valid_o      = vld_q;
  assign out_char_o       = ch_q;
  assign last_of_run_o    = lst_q;
  assign frame_done_o     = done_q;
  assign stuffing_error_o = err_q;

endmodule

// ===== hdl/dfs_checker.sv =====
`timescale 1ns / 1ps
module dfs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_char_o,
  input logic       last_of_run_o,
  input logic       frame_done_o,
  input logic       stuffing_error_o
);

  // stalled result transfer keeps valid and payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o) &&
    $stable(last_of_run_o) && $stable(frame_done_o) && $stable(stuffing_error_o))
    else $error("output changed while stalled");

  // frame close is always the end of a run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> last_of_run_o)
    else $error("frame_done without last_of_run");

  // a flagged character is a run of one
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stuffing_error_o |-> last_of_run_o)
    else $error("stuffing_error not on last result");

  // nothing leaves the block in the cycle after reset releases
  a_reset_idle: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind dle_frame_stuffer dfs_checker u_dfs_checker (.*);
